### design/acis_pkg.sv
`default_nettype none
package acis_pkg;

    localparam int BYTE_W     = 8;
    localparam int PC_W       = 16;
    // Depth of the data store; a power of two, so the address wrap is a mask.
    localparam int DATA_DEPTH = 32;
    localparam int ADDR_W     = $clog2(DATA_DEPTH);
    localparam int MEM_ADDR_W = 5;
    localparam int PC_STEP    = 3;

    typedef enum logic [BYTE_W-1:0] {
        OP_DEC_A      = 8'h14,
        OP_RET        = 8'h22,
        OP_ADD_IMM    = 8'h34,
        OP_ORL_IMM    = 8'h44,
        OP_ANL_IMM    = 8'h54,
        OP_MOV_A_IMM  = 8'h74,
        OP_MOV_DIR_R0 = 8'h88,
        OP_MOV_R0_DIR = 8'hA8,
        OP_MOV_DIR_A  = 8'hF5,
        OP_MOV_R0_A   = 8'hF8,
        OP_JMP_ZERO   = 8'hFF
    } t_opcode;

    typedef struct packed {
        logic [BYTE_W-1:0] opcode;
        logic [BYTE_W-1:0] addr_high;
        logic [BYTE_W-1:0] operand_low;
    } t_instr;

    typedef struct packed {
        logic [BYTE_W-1:0]     acc_value;
        logic [BYTE_W-1:0]     r0_value;
        logic [PC_W-1:0]       next_pc;
        logic                  mem_wrote;
        logic [MEM_ADDR_W-1:0] mem_addr;
        logic [BYTE_W-1:0]     mem_data;
        logic                  opcode_known;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_dmem_req;

endpackage
`default_nettype wire

### design/acis_instr_if.sv
`default_nettype none
interface acis_instr_if;
    logic                      valid;
    logic                      ready;
    logic [acis_pkg::BYTE_W-1:0] opcode;
    logic [acis_pkg::BYTE_W-1:0] addr_high;
    logic [acis_pkg::BYTE_W-1:0] operand_low;

    modport source (output valid, output opcode, output addr_high, output operand_low,
                    input ready);
    modport sink (input valid, input opcode, input addr_high, input operand_low,
                  output ready);
endinterface
`default_nettype wire

### design/acis_result_if.sv
`default_nettype none
interface acis_result_if;
    logic                            valid;
    logic                            ready;
    logic [acis_pkg::BYTE_W-1:0]     acc_value;
    logic [acis_pkg::BYTE_W-1:0]     r0_value;
    logic [acis_pkg::PC_W-1:0]       next_pc;
    logic                            mem_wrote;
    logic [acis_pkg::MEM_ADDR_W-1:0] mem_addr;
    logic [acis_pkg::BYTE_W-1:0]     mem_data;
    logic                            opcode_known;

    modport source (output valid, output acc_value, output r0_value, output next_pc,
                    output mem_wrote, output mem_addr, output mem_data,
                    output opcode_known, input ready);
    modport sink (input valid, input acc_value, input r0_value, input next_pc,
                  input mem_wrote, input mem_addr, input mem_data,
                  input opcode_known, output ready);
endinterface
`default_nettype wire

### design/acis_dstore.sv
`default_nettype none
module acis_dstore (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acis_pkg::t_dmem_req           i_req,
    input  logic                          i_rd_en,
    input  logic [acis_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [acis_pkg::BYTE_W-1:0]   o_rd_data
);
    import acis_pkg::*;

    logic [BYTE_W-1:0] r_mem [DATA_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Clear every entry at reset; write one byte per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DATA_DEPTH; i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    // Read alongside the input register load; forward a write to the same
    // entry that lands on that edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_data <= '0;
        end else if (i_rd_en) begin
            if (i_req.we && (i_req.addr == i_rd_addr)) begin
                r_rd_data <= i_req.wdata;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### design/acis_core.sv
`default_nettype none
module acis_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  acis_pkg::t_instr              i_instr,
    input  logic [acis_pkg::BYTE_W-1:0]   i_rd_data,
    output acis_pkg::t_dmem_req           o_dmem_req,
    output acis_pkg::t_result             o_result
);
    import acis_pkg::*;

    logic [BYTE_W-1:0] r_acc;
    logic [BYTE_W-1:0] r_r0;
    logic [PC_W-1:0]   r_pc;
    logic [BYTE_W-1:0] n_acc;
    logic [BYTE_W-1:0] n_r0;
    logic [PC_W-1:0]   n_pc;

    logic              known;
    logic              to_zero;
    logic              wrote;
    logic              touched;
    logic [BYTE_W-1:0] mdata;
    logic [ADDR_W-1:0] addr;

    // Direct address wraps to the store depth: keep the low bits.
    assign addr = ADDR_W'({i_instr.addr_high, i_instr.operand_low});

    always_comb begin
        n_acc   = r_acc;
        n_r0    = r_r0;
        known   = 1'b1;
        to_zero = 1'b0;
        wrote   = 1'b0;
        touched = 1'b0;
        mdata   = '0;
        case (i_instr.opcode)
            OP_DEC_A:     n_acc = r_acc - BYTE_W'(1);
            OP_RET:       to_zero = 1'b1;
            OP_ADD_IMM:   n_acc = r_acc + i_instr.operand_low;
            OP_ORL_IMM:   n_acc = r_acc | i_instr.operand_low;
            OP_ANL_IMM:   n_acc = r_acc & i_instr.operand_low;
            OP_MOV_A_IMM: n_acc = i_instr.operand_low;
            OP_MOV_DIR_R0: begin
                mdata   = r_r0;
                wrote   = 1'b1;
                touched = 1'b1;
            end
            OP_MOV_R0_DIR: begin
                n_r0    = i_rd_data;
                mdata   = i_rd_data;
                touched = 1'b1;
            end
            OP_MOV_DIR_A: begin
                mdata   = r_acc;
                wrote   = 1'b1;
                touched = 1'b1;
            end
            OP_MOV_R0_A:  n_r0 = r_acc;
            OP_JMP_ZERO:  to_zero = 1'b1;
            default:      known = 1'b0;
        endcase
        n_pc = to_zero ? '0 : r_pc + PC_W'(PC_STEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_r0  <= '0;
            r_pc  <= '0;
        end else if (i_fire) begin
            r_acc <= n_acc;
            r_r0  <= n_r0;
            r_pc  <= n_pc;
        end
    end

    assign o_dmem_req.we    = i_fire && wrote;
    assign o_dmem_req.addr  = addr;
    assign o_dmem_req.wdata = mdata;

    assign o_result.acc_value    = n_acc;
    assign o_result.r0_value     = n_r0;
    assign o_result.next_pc      = n_pc;
    assign o_result.mem_wrote    = wrote;
    assign o_result.mem_addr     = touched ? MEM_ADDR_W'(addr) : '0;
    assign o_result.mem_data     = mdata;
    assign o_result.opcode_known = known;

    a_pc_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_instr.opcode == OP_RET || i_instr.opcode == OP_JMP_ZERO)
        |=> r_pc == '0)
        else $error("PC not cleared after a jump to zero");

    a_unknown_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !known |=> $stable(r_acc) && $stable(r_r0))
        else $error("unknown opcode changed A or R0");

endmodule
`default_nettype wire

### design/accumulator_cpu_instruction_step.sv
`default_nettype none
// Accumulator CPU instruction step. Each transfer on i_instr carries one
// three-byte instruction (opcode, high address byte, low byte); each
// transfer on o_result reports A, R0 and the PC after it, plus the data
// store access it made (address wrapped to the 32-byte store, data moved,
// write flag) and whether the opcode was recognized. A, R0, PC and the data
// store all clear at reset. Throughput is one instruction per clock while
// o_result takes results: the input register feeds the execute logic, which
// updates the architectural state and loads the result register in the
// same cycle, so a dependent instruction can follow directly. The data store
// is read on the edge that loads the input register, so the read byte sits
// beside the held instruction. A result is valid once its instruction has
// executed into the result register, and it is held there until taken. The
// input register keeps taking transfers while a result waits on o_result,
// until both stages are full; ready then drops until the result is taken.
module accumulator_cpu_instruction_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    acis_instr_if.sink   i_instr,
    acis_result_if.source o_result
);
    import acis_pkg::*;

    t_instr            r_in;
    logic              r_in_valid;
    t_result           r_out;
    logic              r_out_valid;
    logic              in_fire;
    logic              exec_fire;
    t_result           core_result;
    t_dmem_req         dmem_req;
    logic [BYTE_W-1:0] rd_data;
    logic [ADDR_W-1:0] rd_addr;

    // Execute when an instruction is held and the result register can take it.
    assign exec_fire     = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_instr.ready = !r_in_valid || exec_fire;
    assign in_fire       = i_instr.valid && i_instr.ready;

    // Store address of the incoming instruction, wrapped to the depth.
    assign rd_addr = ADDR_W'({i_instr.addr_high, i_instr.operand_low});

    // Input register: load on transfer, drop once executed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.opcode      <= i_instr.opcode;
            r_in.addr_high   <= i_instr.addr_high;
            r_in.operand_low <= i_instr.operand_low;
        end
    end

    acis_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (exec_fire),
        .i_instr    (r_in),
        .i_rd_data  (rd_data),
        .o_dmem_req (dmem_req),
        .o_result   (core_result)
    );

    acis_dstore u_dstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (dmem_req),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result register: hold until the downstream transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.acc_value    = r_out.acc_value;
    assign o_result.r0_value     = r_out.r0_value;
    assign o_result.next_pc      = r_out.next_pc;
    assign o_result.mem_wrote    = r_out.mem_wrote;
    assign o_result.mem_addr     = r_out.mem_addr;
    assign o_result.mem_data     = r_out.mem_data;
    assign o_result.opcode_known = r_out.opcode_known;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_instr.ready)
        else $error("input stalled with empty input register");

    a_exec_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> r_out_valid)
        else $error("executed instruction lost its result");

    a_write_is_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.mem_wrote |-> r_out.opcode_known)
        else $error("store write reported for unknown opcode");

endmodule
`default_nettype wire

### test/acis_result_checker.sv
`default_nettype none
// Watches both channels, predicts each result from the instruction that
// went in, and compares it field by field with what comes out.
module acis_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    acis_instr_if         i_instr_mon,
    acis_result_if        i_result_mon,
    output int unsigned   o_fail_count,
    output int unsigned   o_pending
);
    import acis_pkg::*;

    logic [BYTE_W-1:0] acc_q;
    logic [BYTE_W-1:0] r0_q;
    logic [PC_W-1:0]   pc_q;
    logic [BYTE_W-1:0] store_q [DATA_DEPTH];

    t_result pending_results [$];

    // Execute one instruction on the shadow state; return what it reports.
    function automatic t_result run_instr(input t_instr ins);
        t_result           res;
        logic [PC_W-1:0]   full_addr;
        logic [ADDR_W-1:0] idx;
        logic              jump;
        logic              touched;
        full_addr = {ins.addr_high, ins.operand_low};
        idx       = ADDR_W'(full_addr % DATA_DEPTH);
        jump      = 1'b0;
        touched   = 1'b0;
        res       = '0;
        res.opcode_known = 1'b1;
        case (ins.opcode)
            OP_DEC_A:     acc_q = acc_q - 8'd1;
            OP_RET:       jump = 1'b1;
            OP_ADD_IMM:   acc_q = acc_q + ins.operand_low;
            OP_ORL_IMM:   acc_q = acc_q | ins.operand_low;
            OP_ANL_IMM:   acc_q = acc_q & ins.operand_low;
            OP_MOV_A_IMM: acc_q = ins.operand_low;
            OP_MOV_DIR_R0: begin
                store_q[idx]  = r0_q;
                res.mem_data  = r0_q;
                res.mem_wrote = 1'b1;
                touched       = 1'b1;
            end
            OP_MOV_R0_DIR: begin
                r0_q         = store_q[idx];
                res.mem_data = r0_q;
                touched      = 1'b1;
            end
            OP_MOV_DIR_A: begin
                store_q[idx]  = acc_q;
                res.mem_data  = acc_q;
                res.mem_wrote = 1'b1;
                touched       = 1'b1;
            end
            OP_MOV_R0_A:  r0_q = acc_q;
            OP_JMP_ZERO:  jump = 1'b1;
            default:      res.opcode_known = 1'b0;
        endcase
        pc_q = jump ? '0 : pc_q + PC_W'(PC_STEP);
        res.acc_value = acc_q;
        res.r0_value  = r0_q;
        res.next_pc   = pc_q;
        if (touched) begin
            res.mem_addr = MEM_ADDR_W'(idx);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [PC_W-1:0] want,
                               input logic [PC_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_instr  ins;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            acc_q = '0;
            r0_q  = '0;
            pc_q  = '0;
            for (int i = 0; i < DATA_DEPTH; i++) begin
                store_q[i] = '0;
            end
            pending_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_result_mon.valid === 1'b1 && i_result_mon.ready === 1'b1) begin
                got.acc_value    = i_result_mon.acc_value;
                got.r0_value     = i_result_mon.r0_value;
                got.next_pc      = i_result_mon.next_pc;
                got.mem_wrote    = i_result_mon.mem_wrote;
                got.mem_addr     = i_result_mon.mem_addr;
                got.mem_data     = i_result_mon.mem_data;
                got.opcode_known = i_result_mon.opcode_known;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, actual 0x%0h", $time, got);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("acc_value", PC_W'(want.acc_value), PC_W'(got.acc_value));
                    check_field("r0_value", PC_W'(want.r0_value), PC_W'(got.r0_value));
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("mem_wrote", PC_W'(want.mem_wrote), PC_W'(got.mem_wrote));
                    check_field("mem_addr", PC_W'(want.mem_addr), PC_W'(got.mem_addr));
                    check_field("mem_data", PC_W'(want.mem_data), PC_W'(got.mem_data));
                    check_field("opcode_known", PC_W'(want.opcode_known),
                                PC_W'(got.opcode_known));
                end
            end
            if (i_instr_mon.valid === 1'b1 && i_instr_mon.ready === 1'b1) begin
                ins.opcode      = i_instr_mon.opcode;
                ins.addr_high   = i_instr_mon.addr_high;
                ins.operand_low = i_instr_mon.operand_low;
                pending_results.push_back(run_instr(ins));
            end
        end
        o_pending <= pending_results.size();
    end
endmodule
`default_nettype wire

### test/tb_accumulator_cpu_instruction_step.sv
`default_nettype none
// Top of the testbench: drives instructions into the block, drains its
// results with random back-pressure, and gives the verdict. All prediction
// and comparison lives in the checker instantiated beside the block.
module tb_accumulator_cpu_instruction_step;
    import acis_pkg::*;

    localparam int RANDOM_ITEMS   = 700;
    localparam int IDLE_PCT       = 22;
    localparam int WATCHDOG_LIMIT = 200;
    // Extra wait after draining, to catch any stray result.
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_KNOWN      = 11;

    // Opcodes the block does not decode, used in the directed part.
    localparam logic [BYTE_W-1:0] OP_UNMAPPED_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] OP_UNMAPPED_HIGH = 8'hFE;

    localparam t_opcode KNOWN_OPS [NUM_KNOWN] = '{
        OP_DEC_A, OP_RET, OP_ADD_IMM, OP_ORL_IMM, OP_ANL_IMM, OP_MOV_A_IMM,
        OP_MOV_DIR_R0, OP_MOV_R0_DIR, OP_MOV_DIR_A, OP_MOV_R0_A, OP_JMP_ZERO
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        gaps_on      = 1'b1;
    logic        result_ready = 1'b0;
    int unsigned fail_count;
    int unsigned results_pending;
    int unsigned quiet_cycles = 0;

    acis_instr_if  instr_ch ();
    acis_result_if result_ch ();

    assign result_ch.ready = result_ready;

    accumulator_cpu_instruction_step i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch),
        .o_result (result_ch)
    );

    acis_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr_mon  (instr_ch),
        .i_result_mon (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Receiver side: drop ready with a chance of IDLE_PCT percent, except
    // during the stretch where gaps are switched off.
    always @(posedge i_clk) begin
        result_ready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // Watchdog: end the run if no transfer happens on either channel for
    // too long.
    always @(posedge i_clk) begin
        if ((instr_ch.valid === 1'b1 && instr_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("accumulator_cpu_instruction_step: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one instruction, with random idle cycles ahead of it, and hold
    // it until the transfer happens. Valid stays high on return so that a
    // following instruction can go back to back.
    task automatic push_instr(input logic [BYTE_W-1:0] op, input logic [BYTE_W-1:0] hi,
                              input logic [BYTE_W-1:0] lo);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            instr_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        instr_ch.valid       <= 1'b1;
        instr_ch.opcode      <= op;
        instr_ch.addr_high   <= hi;
        instr_ch.operand_low <= lo;
        @(posedge i_clk);
        while (instr_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic wait_drained();
        instr_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (results_pending != 0);
    endtask

    initial begin
        logic [BYTE_W-1:0] op;
        logic [3:0]        pick;
        instr_ch.valid       <= 1'b0;
        instr_ch.opcode      <= '0;
        instr_ch.addr_high   <= '0;
        instr_ch.operand_low <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: wrap of the arithmetic, every opcode, address wrap,
        // reads of zeroed entries, unknown opcodes.
        push_instr(OP_MOV_R0_DIR, 8'h00, 8'h05);     // read of a cleared entry
        push_instr(OP_DEC_A, 8'h00, 8'h00);          // 0 - 1 wraps to 0xFF
        push_instr(OP_ADD_IMM, 8'h00, 8'h01);        // 0xFF + 1 wraps to 0
        push_instr(OP_MOV_A_IMM, 8'hFF, 8'hFF);
        push_instr(OP_ADD_IMM, 8'h00, 8'hFF);
        push_instr(OP_ORL_IMM, 8'h00, 8'h01);
        push_instr(OP_ANL_IMM, 8'hFF, 8'h00);
        push_instr(OP_ANL_IMM, 8'h00, 8'hFF);
        push_instr(OP_MOV_A_IMM, 8'h00, 8'hA5);
        push_instr(OP_MOV_R0_A, 8'h00, 8'h00);
        push_instr(OP_MOV_DIR_R0, 8'hFF, 8'hFF);     // top address folds to 31
        push_instr(OP_MOV_A_IMM, 8'h00, 8'h5A);
        push_instr(OP_MOV_DIR_A, 8'h00, 8'h00);
        push_instr(OP_MOV_R0_DIR, 8'h00, 8'h20);     // 0x20 folds onto entry 0
        push_instr(OP_MOV_R0_DIR, 8'hAB, 8'h1F);
        push_instr(OP_MOV_R0_DIR, 8'h12, 8'h07);     // never written, reads 0
        push_instr(OP_RET, 8'h00, 8'h00);
        push_instr(OP_ADD_IMM, 8'h80, 8'h80);
        push_instr(OP_JMP_ZERO, 8'hFF, 8'hFF);
        push_instr(OP_UNMAPPED_ZERO, 8'h00, 8'h00);
        push_instr(OP_UNMAPPED_HIGH, 8'hFF, 8'hFF);
        push_instr(OP_DEC_A, 8'hFF, 8'hFF);
        wait_drained();

        // Random part: mostly decoded opcodes with random operands, some raw
        // bytes as noise. One pause drains the block; one stretch runs with
        // no idling on either side.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100) begin
                wait_drained();
            end
            if (i == 300) begin
                gaps_on <= 1'b0;
            end
            if (i == 450) begin
                gaps_on <= 1'b1;
            end
            if ($urandom_range(99) < 15) begin
                op = 8'($urandom_range(255));
            end else begin
                pick = 4'($urandom_range(NUM_KNOWN - 1));
                op   = KNOWN_OPS[pick];
            end
            push_instr(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end

        // Drain: wait out every outstanding result, then a few more cycles
        // to catch anything extra.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("accumulator_cpu_instruction_step: match");
        end else begin
            $display("accumulator_cpu_instruction_step: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

### accumulator_cpu_instruction_step.f
design/acis_pkg.sv
design/acis_instr_if.sv
design/acis_result_if.sv
design/acis_dstore.sv
design/acis_core.sv
design/accumulator_cpu_instruction_step.sv
test/acis_result_checker.sv
test/tb_accumulator_cpu_instruction_step.sv
